[sv/sacl_pkg.sv]
// ---------------------------------------------------------------------------
// sacl_pkg: shared types and constants
// Status and command codes, register indexes, reset values and the default
// sizes of the set-associative write-back cache tag core.
// ---------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

	localparam int DEF_MAX_SETS        = 256;
	localparam int DEF_MAX_WAYS        = 8;
	localparam int DEF_MAX_OFFSET_BITS = 8;

	localparam int TAG_W     = 29;
	localparam int ADDR_W    = 32;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int SIZE_W    = 4;
	localparam int MIN_OFFSET_BITS = 3;

	localparam logic [CFG_W-1:0] RST_INDEX_BITS  = 4'd0;
	localparam logic [CFG_W-1:0] RST_OFFSET_BITS = 4'd3;
	localparam logic [CFG_W-1:0] RST_WAYS        = 4'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INDEX_BITS  = 2'd0,
		CFG_OFFSET_BITS = 2'd1,
		CFG_WAYS        = 2'd2
	} cfg_reg_t;

	// A write is 'W' and a read is 'R' in trace terms.
	typedef enum logic {
		CMD_READ  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_HIT        = 2'd0,
		STATUS_MISS       = 2'd1,
		STATUS_BAD_SIZE   = 2'd2,
		STATUS_MISALIGNED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REFS_NONE      = 2'd0,
		REFS_FILL      = 2'd1,
		REFS_WB_FILL   = 2'd2,
		REFS_UNUSED    = 2'd3
	} refs_t;

	typedef struct packed {
		logic  hit;
		refs_t mem_refs;
	} look_t;

endpackage

`default_nettype wire

[sv/sacl_ram.sv]
// ---------------------------------------------------------------------------
// sacl_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; the read data holds while
// the read enable is low.
// ---------------------------------------------------------------------------
`default_nettype none

module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[sv/sacl_lookup.sv]
// ---------------------------------------------------------------------------
// sacl_lookup: set lookup and replacement update
// Compares the tag against the ways in use, picks the hit way or the least
// recently used victim, and builds the updated set row.
// ---------------------------------------------------------------------------
`default_nettype none

module sacl_lookup #(
	parameter int MAX_WAYS = sacl_pkg::DEF_MAX_WAYS,
	parameter int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
	parameter int WAYC_W   = $clog2(MAX_WAYS + 1)
) (
	input  logic                                         enable,
	input  logic                                         cmd,
	input  logic [sacl_pkg::TAG_W-1:0]                   tag,
	input  logic [WAYC_W-1:0]                            ways,
	input  logic [MAX_WAYS-1:0]                          valid_in,
	input  logic [MAX_WAYS-1:0]                          dirty_in,
	input  logic [MAX_WAYS-1:0][sacl_pkg::TAG_W-1:0]     tags_in,
	input  logic [MAX_WAYS-1:0][WAY_W-1:0]               lru_in,
	output sacl_pkg::look_t                              look,
	output logic [MAX_WAYS-1:0]                          valid_out,
	output logic [MAX_WAYS-1:0]                          dirty_out,
	output logic [MAX_WAYS-1:0][sacl_pkg::TAG_W-1:0]     tags_out,
	output logic [MAX_WAYS-1:0][WAY_W-1:0]               lru_out
);

	import sacl_pkg::*;

	logic [MAX_WAYS-1:0]             hit_vec;
	logic [WAY_W-1:0]                hit_way;
	logic [WAY_W-1:0]                victim;
	logic [WAY_W-1:0]                way_sel;
	logic [WAY_W-1:0]                pos;
	logic [MAX_WAYS-1:0][WAY_W-1:0]  lru_new;
	logic                            any_hit;

	always_comb begin
		hit_way = '0;
		victim  = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			hit_vec[w] = valid_in[w] && (tags_in[w] == tag) && (WAYC_W'(w) < ways);
			if (hit_vec[w]) begin
				hit_way = WAY_W'(w);
			end
		end
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (WAYC_W'(lru_in[i]) < ways) begin
				victim = lru_in[i];
			end
		end
	end

	assign any_hit = |hit_vec;
	assign way_sel = any_hit ? hit_way : victim;

	always_comb begin
		pos = '0;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (lru_in[i] == way_sel) begin
				pos = WAY_W'(i);
			end
		end
		for (int i = 0; i < MAX_WAYS - 1; i++) begin
			lru_new[i] = (WAY_W'(i) < pos) ? lru_in[i] : lru_in[i + 1];
		end
		lru_new[MAX_WAYS - 1] = way_sel;
	end

	always_comb begin
		valid_out = valid_in;
		dirty_out = dirty_in;
		tags_out  = tags_in;
		lru_out   = lru_in;
		look.hit      = any_hit;
		look.mem_refs = REFS_NONE;
		if (enable) begin
			lru_out = lru_new;
			if (any_hit) begin
				if (cmd == CMD_WRITE) begin
					dirty_out[hit_way] = 1'b1;
				end
			end else begin
				look.mem_refs     = dirty_in[victim] ? REFS_WB_FILL : REFS_FILL;
				valid_out[victim] = 1'b1;
				dirty_out[victim] = cmd;
				tags_out[victim]  = tag;
			end
		end
	end

endmodule

`default_nettype wire

[sv/set_assoc_writeback_cache_lru_core.sv]
// ---------------------------------------------------------------------------
// set_assoc_writeback_cache_lru_core: tag and LRU core of a write-back cache
// Looks up each access in a set-associative tag store with true LRU order,
// reports hit or miss and the memory references, and keeps hit/miss counts.
// ---------------------------------------------------------------------------
// Usage: an access item (cmd, access_size, address) enters on in_valid while
// in_stall is low. One result item (status, split address, mem_refs and the
// running totals) leaves on out_valid, held until out_stall is low.
// Each accepted item passes the lookup stage registers and then the result
// register, and a new item is accepted every cycle while in_stall is low:
// one set row is read from the tag RAM per item and written back when the
// item moves on, with the written row forwarded to a next item of that set.
// When out_stall holds a result and an item waits in the lookup stage,
// in_stall rises; otherwise an item is taken while a result waits.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Reset clears the configuration to its defaults, the counters and one
// valid bit per set row; a row never written reads as empty with LRU order
// way 0 first, so no clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module set_assoc_writeback_cache_lru_core #(
	parameter int MAX_SETS        = sacl_pkg::DEF_MAX_SETS,
	parameter int MAX_WAYS        = sacl_pkg::DEF_MAX_WAYS,
	parameter int MAX_OFFSET_BITS = sacl_pkg::DEF_MAX_OFFSET_BITS,
	parameter int IDX_MAX         = $clog2(MAX_SETS + 1) - 1,
	parameter int SET_W           = (IDX_MAX > 0) ? IDX_MAX : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sacl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sacl_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             cmd,
	input  logic [sacl_pkg::SIZE_W-1:0]      access_size,
	input  logic [sacl_pkg::ADDR_W-1:0]      address,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       status,
	output logic [sacl_pkg::TAG_W-1:0]       tag_out,
	output logic [SET_W-1:0]                 set_index,
	output logic [MAX_OFFSET_BITS-1:0]       byte_offset,
	output logic [1:0]                       mem_refs,
	output logic [31:0]                      hit_total,
	output logic [31:0]                      miss_total
);

	import sacl_pkg::*;

	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAYC_W = $clog2(MAX_WAYS + 1);
	localparam int ROWS   = 1 << IDX_MAX;
	localparam int ROW_W  = MAX_WAYS * (2 + TAG_W + WAY_W);
	localparam int CNT_W  = 32;

	localparam logic [CFG_W-1:0] IDX_LIM  = CFG_W'(IDX_MAX);
	localparam logic [CFG_W-1:0] OFF_LIM  = CFG_W'(MAX_OFFSET_BITS);
	localparam logic [CFG_W-1:0] OFF_MIN  = CFG_W'(MIN_OFFSET_BITS);
	localparam logic [CFG_W:0]   WAYS_LIM = (CFG_W + 1)'(MAX_WAYS);

	// Configuration.
	logic [CFG_W-1:0] index_bits_q;
	logic [CFG_W-1:0] offset_bits_q;
	logic [CFG_W-1:0] ways_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q  <= RST_INDEX_BITS;
			offset_bits_q <= RST_OFFSET_BITS;
			ways_q        <= RST_WAYS;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_INDEX_BITS:  index_bits_q  <= cfg_data;
				CFG_OFFSET_BITS: offset_bits_q <= cfg_data;
				CFG_WAYS:        ways_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [CFG_W-1:0]  eff_ib;
	logic [CFG_W-1:0]  eff_ob;
	logic [CFG_W:0]    ways_ext;
	logic [CFG_W:0]    ways_sat;
	logic [WAYC_W-1:0] eff_ways;

	always_comb begin
		eff_ib = (index_bits_q > IDX_LIM) ? IDX_LIM : index_bits_q;
		eff_ob = offset_bits_q;
		if (eff_ob < OFF_MIN) begin
			eff_ob = OFF_MIN;
		end
		if (eff_ob > OFF_LIM) begin
			eff_ob = OFF_LIM;
		end
		ways_ext = {1'b0, ways_q};
		ways_sat = ways_ext;
		if (ways_sat == '0) begin
			ways_sat = (CFG_W + 1)'(1);
		end
		if (ways_sat > WAYS_LIM) begin
			ways_sat = WAYS_LIM;
		end
		eff_ways = WAYC_W'(ways_sat);
	end

	// Address split and access checks on the incoming item.
	logic [ADDR_W-1:0] off_mask;
	logic [ADDR_W-1:0] off_full;
	logic [ADDR_W-1:0] set_full;
	logic [ADDR_W-1:0] tag_full;
	logic [CFG_W:0]    tag_shift;
	logic [SET_W-1:0]  set_in;
	logic              size_ok;
	logic              aligned;

	always_comb begin
		off_mask  = (ADDR_W'(1) << eff_ob) - ADDR_W'(1);
		off_full  = address & off_mask;
		set_full  = (address >> eff_ob) & ((ADDR_W'(1) << eff_ib) - ADDR_W'(1));
		tag_shift = {1'b0, eff_ib} + {1'b0, eff_ob};
		tag_full  = address >> tag_shift;
		set_in    = set_full[SET_W-1:0];
		size_ok   = access_size inside {4'd1, 4'd2, 4'd4, 4'd8};
		aligned   = (off_full[SIZE_W-1:0] & (access_size - SIZE_W'(1))) == '0;
	end

	// Handshake.
	logic out_valid_q;
	logic valid_s1;
	logic advance;
	logic accept;
	logic commit;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;
	assign commit   = valid_s1 && advance;

	// Lookup stage registers.
	logic                      cmd_s1;
	logic                      ok_s1;
	status_t                   rej_s1;
	logic [TAG_W-1:0]          tag_s1;
	logic [SET_W-1:0]          set_s1;
	logic [MAX_OFFSET_BITS-1:0] off_s1;
	logic                      rowv_s1;
	logic                      fwd_s1;
	logic [ROWS-1:0]           rowv_q;
	logic [ROW_W-1:0]          fwd_row_q;
	logic [ROW_W-1:0]          new_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rowv_q   <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (commit) begin
				rowv_q[set_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd;
			ok_s1   <= size_ok && aligned;
			rej_s1  <= size_ok ? STATUS_MISALIGNED : STATUS_BAD_SIZE;
			tag_s1  <= tag_full[TAG_W-1:0];
			set_s1  <= set_in;
			off_s1  <= off_full[MAX_OFFSET_BITS-1:0];
			rowv_s1 <= rowv_q[set_in];
			fwd_s1  <= commit && (set_s1 == set_in);
		end
		if (commit) begin
			fwd_row_q <= new_row;
		end
	end

	// Set row store.
	logic [ROW_W-1:0] ram_rdata;

	sacl_ram #(
		.WIDTH (ROW_W),
		.DEPTH (ROWS),
		.AW    (SET_W)
	) u_row_ram (
		.clk   (clk),
		.we    (commit),
		.waddr (set_s1),
		.wdata (new_row),
		.re    (accept),
		.raddr (set_in),
		.rdata (ram_rdata)
	);

	logic [MAX_WAYS-1:0][WAY_W-1:0]  lru_init;
	logic [ROW_W-1:0]                init_row;
	logic [ROW_W-1:0]                cur_row;
	logic [MAX_WAYS-1:0]             cur_valid;
	logic [MAX_WAYS-1:0]             cur_dirty;
	logic [MAX_WAYS-1:0][TAG_W-1:0]  cur_tags;
	logic [MAX_WAYS-1:0][WAY_W-1:0]  cur_lru;
	logic [MAX_WAYS-1:0]             upd_valid;
	logic [MAX_WAYS-1:0]             upd_dirty;
	logic [MAX_WAYS-1:0][TAG_W-1:0]  upd_tags;
	logic [MAX_WAYS-1:0][WAY_W-1:0]  upd_lru;
	look_t                           look;

	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			lru_init[i] = WAY_W'(i);
		end
		init_row = {{(2 * MAX_WAYS){1'b0}}, {(MAX_WAYS * TAG_W){1'b0}}, lru_init};
		if (fwd_s1) begin
			cur_row = fwd_row_q;
		end else if (rowv_s1) begin
			cur_row = ram_rdata;
		end else begin
			cur_row = init_row;
		end
	end

	assign {cur_valid, cur_dirty, cur_tags, cur_lru} = cur_row;
	assign new_row = {upd_valid, upd_dirty, upd_tags, upd_lru};

	sacl_lookup #(
		.MAX_WAYS (MAX_WAYS),
		.WAY_W    (WAY_W),
		.WAYC_W   (WAYC_W)
	) u_lookup (
		.enable    (ok_s1),
		.cmd       (cmd_s1),
		.tag       (tag_s1),
		.ways      (eff_ways),
		.valid_in  (cur_valid),
		.dirty_in  (cur_dirty),
		.tags_in   (cur_tags),
		.lru_in    (cur_lru),
		.look      (look),
		.valid_out (upd_valid),
		.dirty_out (upd_dirty),
		.tags_out  (upd_tags),
		.lru_out   (upd_lru)
	);

	// Counters and result register.
	logic [CNT_W-1:0] hit_q;
	logic [CNT_W-1:0] miss_q;
	logic [CNT_W-1:0] hit_nx;
	logic [CNT_W-1:0] miss_nx;

	assign hit_nx  = hit_q + CNT_W'(ok_s1 && look.hit);
	assign miss_nx = miss_q + CNT_W'(ok_s1 && !look.hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hit_q       <= '0;
			miss_q      <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (commit) begin
				hit_q  <= hit_nx;
				miss_q <= miss_nx;
			end
		end
	end

	status_t                    status_q;
	logic [TAG_W-1:0]           tag_q;
	logic [SET_W-1:0]           set_q;
	logic [MAX_OFFSET_BITS-1:0] off_q;
	refs_t                      refs_q;
	logic [CNT_W-1:0]           hit_tot_q;
	logic [CNT_W-1:0]           miss_tot_q;

	always_ff @(posedge clk) begin
		if (commit) begin
			if (ok_s1) begin
				status_q <= look.hit ? STATUS_HIT : STATUS_MISS;
			end else begin
				status_q <= rej_s1;
			end
			tag_q      <= tag_s1;
			set_q      <= set_s1;
			off_q      <= off_s1;
			refs_q     <= look.mem_refs;
			hit_tot_q  <= hit_nx;
			miss_tot_q <= miss_nx;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign tag_out     = tag_q;
	assign set_index   = set_q;
	assign byte_offset = off_q;
	assign mem_refs    = refs_q;
	assign hit_total   = hit_tot_q;
	assign miss_total  = miss_tot_q;

endmodule

`default_nettype wire
